[rtl/rpn_pkg.sv]
// rpn_pkg: shared constants, codes and command types for the RPN evaluator.
// No dependencies.
package rpn_pkg;

  localparam int StackDepth = 32;
  localparam int CntW = $clog2(StackDepth + 1);
  localparam int PtrW = $clog2(StackDepth);

  localparam logic [2:0] OP_DIGIT = 3'd0;
  localparam logic [2:0] OP_ADD   = 3'd1;
  localparam logic [2:0] OP_SUB   = 3'd2;
  localparam logic [2:0] OP_MUL   = 3'd3;
  localparam logic [2:0] OP_DIV   = 3'd4;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FEW   = 3'd1;
  localparam logic [2:0] ST_OVF   = 3'd2;
  localparam logic [2:0] ST_DIV0  = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;
  localparam logic [2:0] ST_DEPTH = 3'd5;

  // controller -> datapath
  typedef struct packed {
    logic       rd_b;     // read top entry into B
    logic       rd_a;     // read second entry into A
    logic       wr_digit; // write digit at count-1
    logic       wr_res;   // write result at count-2
    logic       rd_out;   // read entry 0 for output
    logic       start;    // start add/sub/mul/div
    logic [2:0] op;
  } rpn_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       done;
    logic [2:0] status;
  } rpn_sts_t;

endpackage

[rtl/rpn_stack_evaluator.sv]
// rpn_stack_evaluator: top level of the RPN expression evaluator.
// Instantiates rpn_ctrl and rpn_datapath; depends on rpn_pkg.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o) carries one token per beat:
//    operation_i (0 digit, 1 add, 2 sub, 3 mul, 4 div), digit_value_i, last_i.
//  - Output channel (out_valid_o / out_stall_i) carries one beat per
//    expression, on the token marked last: value_o and status_o.
//  - A digit or unused code is taken at once; an operator goes through
//    S_RDA, S_WAITA, S_LOADA, S_EXEC and S_WAIT, and mul/div wait on the
//    64-step shift-add / restoring divide unit in the datapath. A last token
//    then holds the input through S_OUTRD (which waits for a pending digit
//    write) and S_OUT while the bottom entry is read and the result loaded.
//  - Errors are sticky; later tokens of the expression are skipped.
//  - Reset clears stack count, error and the output valid; the stack memory
//    itself is not cleared (only entries below the count are read).
//  - The result sits in an output register; while that beat is stalled,
//    in_stall_o stays high and no token is taken until the beat leaves.
module rpn_stack_evaluator import rpn_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [3:0]  digit_value_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] value_o,
  output logic [2:0]  status_o
);

  rpn_cmd_t        cmd;
  rpn_sts_t        sts;
  logic [CntW-1:0] count;
  logic [3:0]      digit;
  logic [63:0]     top0;

  rpn_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .operation_i, .digit_value_i,
    .last_i, .out_valid_o, .out_stall_i, .value_o, .status_o,
    .cmd_o(cmd), .count_o(count), .digit_o(digit), .sts_i(sts), .top0_i(top0)
  );

  rpn_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .count_i(count), .digit_i(digit),
    .sts_o(sts), .top0_o(top0)
  );

endmodule

[rtl/rpn_datapath.sv]
// rpn_datapath: operand stack memory, operand registers and an iterative
// 64-bit multiply / divide unit (one bit per cycle). Depends on rpn_pkg.
module rpn_datapath import rpn_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rpn_cmd_t        cmd_i,
  input  logic [CntW-1:0] count_i,
  input  logic [3:0]      digit_i,
  output rpn_sts_t        sts_o,
  output logic [63:0]     top0_o
);

  logic [63:0] mem_q [StackDepth];
  logic [63:0] rdata_q;
  logic [63:0] a_q, b_q;
  logic        ld_a_q, ld_b_q;

  logic [CntW-1:0] cm1, cm2;
  assign cm1 = count_i - CntW'(1);
  assign cm2 = count_i - CntW'(2);

  // iterative unit
  logic        busy_q, neg_q, done_q;
  logic [2:0]  st_q, op_q;
  logic [6:0]  step_q;
  logic [63:0] ma_q, mb_q, rem_q, quo_q, res_q;
  logic [127:0] acc_q;
  logic [63:0] ma_d, mb_d;
  logic [64:0] trial;
  logic [63:0] sum, dif;
  logic        ovf_add, ovf_sub;
  logic [64:0] mag;

  assign sum = a_q + b_q;
  assign dif = a_q - b_q;
  assign ovf_add = (a_q[63] == b_q[63]) && (sum[63] != a_q[63]);
  assign ovf_sub = (a_q[63] != b_q[63]) && (dif[63] != a_q[63]);
  assign ma_d = a_q[63] ? (~a_q + 64'd1) : a_q;
  assign mb_d = b_q[63] ? (~b_q + 64'd1) : b_q;
  assign trial = {rem_q, quo_q[63]} - {1'b0, mb_q};
  assign mag = neg_q ? 65'h1_0000_0000_0000_0000 : 65'h0_7FFF_FFFF_FFFF_FFFF;

  // digit write comes the cycle after the count was bumped: slot is count-1
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_digit) mem_q[cm1[PtrW-1:0]] <= {60'd0, digit_i};
    if (cmd_i.wr_res)   mem_q[cm2[PtrW-1:0]] <= res_q;
    if (cmd_i.rd_b)     rdata_q <= mem_q[cm1[PtrW-1:0]];
    else if (cmd_i.rd_a) rdata_q <= mem_q[cm2[PtrW-1:0]];
    else if (cmd_i.rd_out) rdata_q <= mem_q[0];
    if (ld_b_q) b_q <= rdata_q;
    if (ld_a_q) a_q <= rdata_q;
  end

  assign top0_o = rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_a_q <= 1'b0;
      ld_b_q <= 1'b0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      st_q   <= ST_OK;
      op_q   <= OP_ADD;
      step_q <= '0;
      neg_q  <= 1'b0;
      ma_q   <= '0;
      mb_q   <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      res_q  <= '0;
      acc_q  <= '0;
    end else begin
      ld_b_q <= cmd_i.rd_b;
      ld_a_q <= cmd_i.rd_a;
      if (cmd_i.start) begin
        op_q <= cmd_i.op;
        unique case (cmd_i.op)
          OP_ADD: begin
            res_q  <= sum;
            st_q   <= ovf_add ? ST_OVF : ST_OK;
            done_q <= 1'b1;
          end
          OP_SUB: begin
            res_q  <= dif;
            st_q   <= ovf_sub ? ST_OVF : ST_OK;
            done_q <= 1'b1;
          end
          OP_MUL, OP_DIV: begin
            if (cmd_i.op == OP_DIV && b_q == 64'd0) begin
              st_q   <= ST_DIV0;
              done_q <= 1'b1;
            end else if (cmd_i.op == OP_DIV && a_q == {1'b1, 63'd0} && b_q == '1) begin
              st_q   <= ST_OVF;
              done_q <= 1'b1;
            end else begin
              st_q   <= ST_OK;
              done_q <= 1'b0;
              busy_q <= 1'b1;
              step_q <= '0;
              ma_q   <= ma_d;
              mb_q   <= mb_d;
              neg_q  <= a_q[63] ^ b_q[63];
              acc_q  <= '0;
              rem_q  <= '0;
              quo_q  <= ma_d;
            end
          end
          default: begin
            st_q   <= ST_OK;
            done_q <= 1'b1;
          end
        endcase
      end else if (busy_q) begin
        if (step_q == 7'd64) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          if (op_q == OP_MUL) begin
            if (acc_q[127:64] != 64'd0 || {1'b0, acc_q[63:0]} > mag) st_q <= ST_OVF;
            res_q <= neg_q ? (~acc_q[63:0] + 64'd1) : acc_q[63:0];
          end else begin
            res_q <= neg_q ? (~quo_q + 64'd1) : quo_q;
          end
        end else begin
          done_q <= 1'b0;
          step_q <= step_q + 7'd1;
          if (op_q == OP_MUL) begin
            // shift-add, LSB of multiplier first
            if (mb_q[0]) acc_q <= {1'b0, acc_q[127:1]} + {1'b0, ma_q, 63'd0};
            else         acc_q <= {1'b0, acc_q[127:1]};
            mb_q <= {1'b0, mb_q[63:1]};
          end else begin
            // restoring divide, one quotient bit per cycle
            if (!trial[64]) begin
              rem_q <= trial[63:0];
              quo_q <= {quo_q[62:0], 1'b1};
            end else begin
              rem_q <= {rem_q[62:0], quo_q[63]};
              quo_q <= {quo_q[62:0], 1'b0};
            end
          end
        end
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  assign sts_o.done   = done_q;
  assign sts_o.status = st_q;

endmodule

[rtl/rpn_ctrl.sv]
// rpn_ctrl: token sequencer; keeps stack count and sticky error, issues
// datapath commands and drives the result register. Depends on rpn_pkg.
module rpn_ctrl import rpn_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [2:0]      operation_i,
  input  logic [3:0]      digit_value_i,
  input  logic            last_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [63:0]     value_o,
  output logic [2:0]      status_o,
  output rpn_cmd_t        cmd_o,
  output logic [CntW-1:0] count_o,
  output logic [3:0]      digit_o,
  input  rpn_sts_t        sts_i,
  input  logic [63:0]     top0_i
);

  typedef enum logic [2:0] {S_IDLE, S_RDA, S_WAITA, S_LOADA, S_EXEC, S_WAIT, S_OUTRD, S_OUT}
    state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic [2:0]      err_q, op_q;
  logic            last_q;
  logic [3:0]      dig_q;
  logic            ovalid_q;
  logic [63:0]     value_q;
  logic [2:0]      status_q;
  logic            accept;
  logic            wr_q, wr_d;
  logic            run_d;

  assign in_stall_o  = (state_q != S_IDLE) || (ovalid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = ovalid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;
  assign count_o     = cnt_q;
  assign digit_o     = dig_q;

  // digit that lands on the stack / operator that goes to the datapath
  assign wr_d  = accept && (err_q == ST_OK) && (operation_i == OP_DIGIT) &&
                 (cnt_q < CntW'(StackDepth));
  assign run_d = accept && (err_q == ST_OK) && (operation_i != OP_DIGIT) &&
                 (operation_i <= OP_DIV) && (cnt_q >= CntW'(2));

  always_comb begin
    cmd_o          = '0;
    cmd_o.op       = op_q;
    cmd_o.wr_digit = wr_q;
    cmd_o.rd_b     = (state_q == S_RDA) && !wr_q;
    cmd_o.rd_a     = (state_q == S_WAITA);
    cmd_o.start    = (state_q == S_EXEC);
    cmd_o.wr_res   = (state_q == S_WAIT) && sts_i.done && sts_i.status == ST_OK;
    cmd_o.rd_out   = (state_q == S_OUTRD) && !wr_q && !cmd_o.wr_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      err_q    <= ST_OK;
      op_q     <= OP_ADD;
      last_q   <= 1'b0;
      dig_q    <= '0;
      ovalid_q <= 1'b0;
      status_q <= ST_OK;
      wr_q     <= 1'b0;
      value_q  <= '0;
    end else begin
      wr_q     <= wr_d;
      ovalid_q <= (state_q == S_OUT) || (ovalid_q && out_stall_i);
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q   <= operation_i;
            last_q <= last_i;
            dig_q  <= digit_value_i;
            if (err_q == ST_OK) begin
              if (operation_i == OP_DIGIT) begin
                if (cnt_q >= CntW'(StackDepth)) err_q <= ST_FULL;
                else cnt_q <= cnt_q + CntW'(1);
              end else if (operation_i <= OP_DIV) begin
                if (cnt_q < CntW'(2)) err_q <= ST_FEW;
              end
            end
            if (run_d) state_q <= S_RDA;
            else if (last_i) state_q <= S_OUTRD;
          end
        end
        S_RDA:   state_q <= S_WAITA;
        S_WAITA: state_q <= S_LOADA;
        S_LOADA: state_q <= S_EXEC;
        S_EXEC:  state_q <= S_WAIT;
        S_WAIT: begin
          if (sts_i.done) begin
            if (sts_i.status == ST_OK) cnt_q <= cnt_q - CntW'(1);
            else err_q <= sts_i.status;
            state_q <= last_q ? S_OUTRD : S_IDLE;
          end
        end
        // a pending digit write must land before entry 0 is read
        S_OUTRD: if (!wr_q) state_q <= S_OUT;
        S_OUT: begin
          if (err_q != ST_OK) begin
            status_q <= err_q;
            value_q  <= '0;
          end else if (cnt_q != CntW'(1)) begin
            status_q <= ST_DEPTH;
            value_q  <= '0;
          end else begin
            status_q <= ST_OK;
            value_q  <= top0_i;
          end
          cnt_q   <= '0;
          err_q   <= ST_OK;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
